// File: hw/rtl/vspm_pkg.sv
// Shared constants, register indexes and types of the viewport scale and pan mapper.
`timescale 1ns / 1ps

package vspm_pkg;

   // Default geometry.
   localparam int VIEWPORT_WIDTH_DEFAULT  = 320;
   localparam int VIEWPORT_HEIGHT_DEFAULT = 240;
   localparam int MAX_IMAGE_DIM_DEFAULT   = 4096;

   // Zoom is expressed in 1/256 units.
   localparam int ZOOM_ONE   = 256;
   localparam int ZOOM_SHIFT = 8;
   localparam int ZOOM_MAX   = 1024;

   localparam int PIXEL_BYTES_MIN = 2;
   localparam int PIXEL_BYTES_MAX = 4;

   // Port widths.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int IMG_DIM_W   = 13;
   localparam int PB_W        = 3;
   localparam int OFFSET_W    = 16;
   localparam int ZOOM_W      = 11;
   localparam int PAN_W       = 15;
   localparam int VIEW_X_W    = 9;
   localparam int VIEW_Y_W    = 8;
   localparam int SRC_W       = 12;
   localparam int ADDR_W      = 27;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_WIDTH       = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_HEIGHT      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_PIXEL_BYTES       = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_ROWS_TOP_DOWN     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_PIXEL_DATA_OFFSET = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_ZOOM_SCALE        = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_PAN_OFFSET_X      = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_PAN_OFFSET_Y      = 3'd7;

   // Reset values.
   localparam logic [IMG_DIM_W-1:0] IMAGE_DIM_RESET   = 13'd1;
   localparam logic [PB_W-1:0]      PIXEL_BYTES_RESET = 3'd2;
   localparam logic [OFFSET_W-1:0]  OFFSET_RESET      = 16'd54;
   localparam logic [ZOOM_W-1:0]    ZOOM_RESET        = 11'd256;

   // One finished result beat.
   typedef struct packed {
      logic              on_image;
      logic [SRC_W-1:0]  source_col;
      logic [SRC_W-1:0]  source_row;
      logic [ADDR_W-1:0] source_byte_address;
   } result_type;

endpackage

// File: hw/rtl/vspm_div_pipe.sv
// Pipelined restoring divider that retires one quotient bit per stage.
`timescale 1ns / 1ps

module vspm_div_pipe #(
   parameter int DEN_W = 16,
   parameter int QW    = 13,
   parameter int TAG_W = 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  logic [DEN_W+QW-1:0]   in_num,
   input  logic [DEN_W-1:0]      den,
   input  logic [TAG_W-1:0]      in_tag,
   output logic                  out_valid,
   output logic [QW-1:0]         out_quot,
   output logic [TAG_W-1:0]      out_tag
);

   // The numerator must be below den * 2**QW, so the upper part starts as a
   // partial remainder below den. The low word shifts out numerator bits and
   // shifts in quotient bits.
   logic             valid_ff [0:QW];
   logic [TAG_W-1:0] tag_ff   [0:QW];
   logic [DEN_W-1:0] rem_ff   [0:QW-1];
   logic [QW-1:0]    lowq_ff  [0:QW];

   logic [DEN_W-1:0] rem_in   [0:QW-1];
   logic [QW-1:0]    lowq_in  [0:QW-1];

   always_comb begin
      logic [DEN_W:0] trial;
      logic           ge;
      for (int k = 0; k < QW; k++) begin
         trial = {rem_ff[k], lowq_ff[k][QW-1]};
         ge    = (trial >= {1'b0, den});
         rem_in[k]  = ge ? DEN_W'(trial - {1'b0, den}) : DEN_W'(trial);
         lowq_in[k] = {lowq_ff[k][QW-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= QW; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else if (en) begin
         valid_ff[0] <= in_valid;
         for (int k = 0; k < QW; k++) begin
            valid_ff[k+1] <= valid_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tag_ff[0]  <= in_tag;
         rem_ff[0]  <= in_num[DEN_W+QW-1:QW];
         lowq_ff[0] <= in_num[QW-1:0];
         for (int k = 0; k < QW; k++) begin
            tag_ff[k+1]  <= tag_ff[k];
            lowq_ff[k+1] <= lowq_in[k];
         end
         for (int k = 0; k < QW-1; k++) begin
            rem_ff[k+1] <= rem_in[k];
         end
      end
   end

   assign out_valid = valid_ff[QW];
   assign out_quot  = lowq_ff[QW];
   assign out_tag   = tag_ff[QW];

endmodule

// File: hw/rtl/viewport_scale_pan_mapper_core.sv
// Top level of the viewport scale and pan mapper: registers, geometry and address pipeline.
`timescale 1ns / 1ps

// This block maps each viewport pixel beat (req_view_x, req_view_y) to a source
// pixel of a stored image that is zoomed, centered and panned in the view, and
// returns whether the pixel lies on the image together with the nearest source
// column, source row and file byte address. It takes one beat in every cycle
// while req_stall is low and returns one result beat per request beat in
// order. The depth is set by the two source coordinate dividers, which
// retire one quotient bit per pipeline stage. The whole pipeline advances
// together; a one entry skid register behind the output register takes the
// beat that is in flight when rsp_stall rises, and req_stall is simply that
// entry being full. The drawn size, origin and row pitch are recomputed from
// the registers every cycle in a short pipeline of their own, so registers
// must only be written while no beat is in flight.
module viewport_scale_pan_mapper_core #(
   parameter int VIEWPORT_WIDTH  = vspm_pkg::VIEWPORT_WIDTH_DEFAULT,
   parameter int VIEWPORT_HEIGHT = vspm_pkg::VIEWPORT_HEIGHT_DEFAULT,
   parameter int MAX_IMAGE_DIM   = vspm_pkg::MAX_IMAGE_DIM_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [vspm_pkg::VIEW_X_W-1:0]      req_view_x,
   input  logic [vspm_pkg::VIEW_Y_W-1:0]      req_view_y,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_on_image,
   output logic [vspm_pkg::SRC_W-1:0]         rsp_source_col,
   output logic [vspm_pkg::SRC_W-1:0]         rsp_source_row,
   output logic [vspm_pkg::ADDR_W-1:0]        rsp_source_byte_address,
   input  logic                               csr_write_enable,
   input  logic [vspm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [vspm_pkg::CSR_DATA_W-1:0]    csr_write_data
);

   localparam int DIM_W   = $clog2(MAX_IMAGE_DIM + 1);
   localparam int WZ_W    = DIM_W + vspm_pkg::ZOOM_W;
   localparam int DRAW_W  = DIM_W + 3;
   localparam int RS_W    = DIM_W + 3;
   localparam int NUM_W   = DRAW_W + DIM_W;
   localparam int MAXW    = (DRAW_W > vspm_pkg::PAN_W) ? DRAW_W : vspm_pkg::PAN_W;
   localparam int S_W     = MAXW + 3;
   localparam int PROD_W  = RS_W + DIM_W;
   localparam int SUM_W   = ((PROD_W > vspm_pkg::ADDR_W) ? PROD_W : vspm_pkg::ADDR_W) + 1;
   localparam int DELAY_N = 6;

   // ---------------------------------------------------------------------
   // Configuration registers.
   // ---------------------------------------------------------------------
   logic [vspm_pkg::IMG_DIM_W-1:0]  width_ff, height_ff;
   logic [vspm_pkg::PB_W-1:0]       pixel_bytes_ff;
   logic                            top_down_ff;
   logic [vspm_pkg::OFFSET_W-1:0]   offset_ff;
   logic [vspm_pkg::ZOOM_W-1:0]     zoom_ff;
   logic signed [vspm_pkg::PAN_W-1:0] pan_x_ff, pan_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff       <= vspm_pkg::IMAGE_DIM_RESET;
         height_ff      <= vspm_pkg::IMAGE_DIM_RESET;
         pixel_bytes_ff <= vspm_pkg::PIXEL_BYTES_RESET;
         top_down_ff    <= 1'b0;
         offset_ff      <= vspm_pkg::OFFSET_RESET;
         zoom_ff        <= vspm_pkg::ZOOM_RESET;
         pan_x_ff       <= '0;
         pan_y_ff       <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            vspm_pkg::REG_IMAGE_WIDTH: begin
               width_ff <= csr_write_data[vspm_pkg::IMG_DIM_W-1:0];
            end
            vspm_pkg::REG_IMAGE_HEIGHT: begin
               height_ff <= csr_write_data[vspm_pkg::IMG_DIM_W-1:0];
            end
            vspm_pkg::REG_PIXEL_BYTES: begin
               pixel_bytes_ff <= csr_write_data[vspm_pkg::PB_W-1:0];
            end
            vspm_pkg::REG_ROWS_TOP_DOWN: begin
               top_down_ff <= csr_write_data[0];
            end
            vspm_pkg::REG_PIXEL_DATA_OFFSET: begin
               offset_ff <= csr_write_data[vspm_pkg::OFFSET_W-1:0];
            end
            vspm_pkg::REG_ZOOM_SCALE: begin
               zoom_ff <= csr_write_data[vspm_pkg::ZOOM_W-1:0];
            end
            vspm_pkg::REG_PAN_OFFSET_X: begin
               pan_x_ff <= $signed(csr_write_data[vspm_pkg::PAN_W-1:0]);
            end
            vspm_pkg::REG_PAN_OFFSET_Y: begin
               pan_y_ff <= $signed(csr_write_data[vspm_pkg::PAN_W-1:0]);
            end
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Geometry pipeline. Each layer is registered from the layers before it;
   // a beat only reads a layer once it has seen the current register values.
   // ---------------------------------------------------------------------
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [vspm_pkg::IMG_DIM_W-1:0] v);
      logic [31:0] e;
      e = 32'(v);
      if (e == 32'd0) begin
         e = 32'd1;
      end else if (e > 32'(MAX_IMAGE_DIM)) begin
         e = 32'(MAX_IMAGE_DIM);
      end
      return DIM_W'(e);
   endfunction

   function automatic logic [DRAW_W-1:0] drawn_dim(input logic [WZ_W-1:0] wz);
      logic [WZ_W:0]       t;
      logic [DRAW_W-1:0]   d;
      t = (WZ_W + 1)'(wz) + (WZ_W + 1)'(vspm_pkg::ZOOM_ONE - 1);
      d = DRAW_W'(t >> vspm_pkg::ZOOM_SHIFT);
      if (d == '0) begin
         d = DRAW_W'(1);
      end
      return d;
   endfunction

   // Layer 1: clamped registers.
   logic [DIM_W-1:0]           wc_ff, hc_ff;
   logic [vspm_pkg::PB_W-1:0]  pbc_ff;
   logic [vspm_pkg::ZOOM_W-1:0] zc_ff;

   always_ff @(posedge clock) begin
      wc_ff <= clamp_dim(width_ff);
      hc_ff <= clamp_dim(height_ff);
      if (32'(pixel_bytes_ff) < 32'(vspm_pkg::PIXEL_BYTES_MIN)) begin
         pbc_ff <= vspm_pkg::PB_W'(vspm_pkg::PIXEL_BYTES_MIN);
      end else if (32'(pixel_bytes_ff) > 32'(vspm_pkg::PIXEL_BYTES_MAX)) begin
         pbc_ff <= vspm_pkg::PB_W'(vspm_pkg::PIXEL_BYTES_MAX);
      end else begin
         pbc_ff <= pixel_bytes_ff;
      end
      if (zoom_ff == '0) begin
         zc_ff <= vspm_pkg::ZOOM_W'(1);
      end else if (32'(zoom_ff) > 32'(vspm_pkg::ZOOM_MAX)) begin
         zc_ff <= vspm_pkg::ZOOM_W'(vspm_pkg::ZOOM_MAX);
      end else begin
         zc_ff <= zoom_ff;
      end
   end

   // Layer 2: products.
   logic [WZ_W-1:0]  wz_ff, hz_ff;
   logic [RS_W-1:0]  pbw_ff;

   always_ff @(posedge clock) begin
      wz_ff  <= WZ_W'(wc_ff) * WZ_W'(zc_ff);
      hz_ff  <= WZ_W'(hc_ff) * WZ_W'(zc_ff);
      pbw_ff <= RS_W'(pbc_ff) * RS_W'(wc_ff);
   end

   // Layer 3: drawn size with ceiling rounding and the 4 byte padded row pitch.
   logic [DRAW_W-1:0] dw_ff, dh_ff;
   logic [RS_W-1:0]   row_size_ff;

   always_ff @(posedge clock) begin
      logic [RS_W-1:0] rounded;
      rounded     = pbw_ff + RS_W'(3);
      dw_ff       <= drawn_dim(wz_ff);
      dh_ff       <= drawn_dim(hz_ff);
      row_size_ff <= {rounded[RS_W-1:2], 2'b00};
   end

   // Layer 4: centering base (truncated toward zero) and pan limit.
   logic signed [S_W-1:0] base_x_ff, base_y_ff, lim_x_ff, lim_y_ff;

   always_ff @(posedge clock) begin
      logic signed [S_W-1:0] diff_x, diff_y;
      diff_x = $signed(S_W'(VIEWPORT_WIDTH)) - $signed(S_W'(dw_ff));
      diff_y = $signed(S_W'(VIEWPORT_HEIGHT)) - $signed(S_W'(dh_ff));
      if (diff_x < 0) begin
         base_x_ff <= -((-diff_x) >>> 1);
         lim_x_ff  <= (-diff_x) >>> 1;
      end else begin
         base_x_ff <= diff_x >>> 1;
         lim_x_ff  <= '0;
      end
      if (diff_y < 0) begin
         base_y_ff <= -((-diff_y) >>> 1);
         lim_y_ff  <= (-diff_y) >>> 1;
      end else begin
         base_y_ff <= diff_y >>> 1;
         lim_y_ff  <= '0;
      end
   end

   // Layer 5: origin after the pan is clamped. The register keeps the request.
   logic signed [S_W-1:0] org_x_ff, org_y_ff;

   always_ff @(posedge clock) begin
      logic signed [S_W-1:0] px, py;
      px = S_W'(pan_x_ff);
      py = S_W'(pan_y_ff);
      if (px < -lim_x_ff) begin
         px = -lim_x_ff;
      end else if (px > lim_x_ff) begin
         px = lim_x_ff;
      end
      if (py < -lim_y_ff) begin
         py = -lim_y_ff;
      end else if (py > lim_y_ff) begin
         py = lim_y_ff;
      end
      org_x_ff <= base_x_ff + px;
      org_y_ff <= base_y_ff + py;
   end

   // Layer 6: far edges of the drawn rectangle.
   logic signed [S_W-1:0] end_x_ff, end_y_ff;

   always_ff @(posedge clock) begin
      end_x_ff <= org_x_ff + $signed(S_W'(dw_ff));
      end_y_ff <= org_y_ff + $signed(S_W'(dh_ff));
   end

   // ---------------------------------------------------------------------
   // Beat pipeline. All stages move together when the skid entry is free.
   // ---------------------------------------------------------------------
   logic advance;
   logic skid_valid_ff;

   assign advance   = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   // Stages 1 to 6 hold the coordinate until the geometry layers are current.
   logic                          dl_valid_ff [1:DELAY_N];
   logic [vspm_pkg::VIEW_X_W-1:0] dl_x_ff     [1:DELAY_N];
   logic [vspm_pkg::VIEW_Y_W-1:0] dl_y_ff     [1:DELAY_N];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 1; k <= DELAY_N; k++) begin
            dl_valid_ff[k] <= 1'b0;
         end
      end else if (advance) begin
         dl_valid_ff[1] <= req_valid;
         for (int k = 1; k < DELAY_N; k++) begin
            dl_valid_ff[k+1] <= dl_valid_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dl_x_ff[1] <= req_view_x;
         dl_y_ff[1] <= req_view_y;
         for (int k = 1; k < DELAY_N; k++) begin
            dl_x_ff[k+1] <= dl_x_ff[k];
            dl_y_ff[k+1] <= dl_y_ff[k];
         end
      end
   end

   // Stage 7: on image test and offset inside the drawn rectangle.
   logic              s7_valid_ff, s7_on_ff;
   logic [DRAW_W-1:0] s7_dx_ff, s7_dy_ff;

   logic signed [S_W-1:0] s7_xs, s7_ys;
   logic                  s7_on_in;

   always_comb begin
      s7_xs    = $signed(S_W'(dl_x_ff[DELAY_N]));
      s7_ys    = $signed(S_W'(dl_y_ff[DELAY_N]));
      s7_on_in = (32'(dl_x_ff[DELAY_N]) < 32'(VIEWPORT_WIDTH))
              && (32'(dl_y_ff[DELAY_N]) < 32'(VIEWPORT_HEIGHT))
              && (s7_xs >= org_x_ff) && (s7_xs < end_x_ff)
              && (s7_ys >= org_y_ff) && (s7_ys < end_y_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_valid_ff <= 1'b0;
      end else if (advance) begin
         s7_valid_ff <= dl_valid_ff[DELAY_N];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s7_on_ff <= s7_on_in;
         // A background beat divides zero so the divider stays in range.
         s7_dx_ff <= s7_on_in ? DRAW_W'(s7_xs - org_x_ff) : '0;
         s7_dy_ff <= s7_on_in ? DRAW_W'(s7_ys - org_y_ff) : '0;
      end
   end

   // Stage 8: scaled numerators.
   logic             s8_valid_ff, s8_on_ff;
   logic [NUM_W-1:0] s8_num_x_ff, s8_num_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s8_valid_ff <= 1'b0;
      end else if (advance) begin
         s8_valid_ff <= s7_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s8_on_ff    <= s7_on_ff;
         s8_num_x_ff <= NUM_W'(s7_dx_ff) * NUM_W'(wc_ff);
         s8_num_y_ff <= NUM_W'(s7_dy_ff) * NUM_W'(hc_ff);
      end
   end

   // Nearest neighbor source coordinates.
   logic             col_valid, row_valid;
   logic [DIM_W-1:0] col_quot, row_quot;
   logic             col_on, row_on;

   vspm_div_pipe #(
      .DEN_W (DRAW_W),
      .QW    (DIM_W),
      .TAG_W (1)
   ) u_col_div (
      .clock     (clock),
      .reset     (reset),
      .en        (advance),
      .in_valid  (s8_valid_ff),
      .in_num    (s8_num_x_ff),
      .den       (dw_ff),
      .in_tag    (s8_on_ff),
      .out_valid (col_valid),
      .out_quot  (col_quot),
      .out_tag   (col_on)
   );

   vspm_div_pipe #(
      .DEN_W (DRAW_W),
      .QW    (DIM_W),
      .TAG_W (1)
   ) u_row_div (
      .clock     (clock),
      .reset     (reset),
      .en        (advance),
      .in_valid  (s8_valid_ff),
      .in_num    (s8_num_y_ff),
      .den       (dh_ff),
      .in_tag    (s8_on_ff),
      .out_valid (row_valid),
      .out_quot  (row_quot),
      .out_tag   (row_on)
   );

   // Stage A: clamp to the last column and row, flip bottom-up storage.
   logic                       sa_valid_ff, sa_on_ff;
   logic [DIM_W-1:0]           sa_col_ff, sa_row_ff, sa_stored_ff;
   logic [RS_W-1:0]            sa_col_bytes_ff;

   logic [DIM_W-1:0] sa_col_in, sa_row_in;

   always_comb begin
      sa_col_in = (col_quot > wc_ff - DIM_W'(1)) ? wc_ff - DIM_W'(1) : col_quot;
      sa_row_in = (row_quot > hc_ff - DIM_W'(1)) ? hc_ff - DIM_W'(1) : row_quot;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sa_valid_ff <= 1'b0;
      end else if (advance) begin
         sa_valid_ff <= col_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sa_on_ff        <= col_on;
         sa_col_ff       <= sa_col_in;
         sa_row_ff       <= sa_row_in;
         sa_stored_ff    <= top_down_ff ? sa_row_in : hc_ff - DIM_W'(1) - sa_row_in;
         sa_col_bytes_ff <= RS_W'(sa_col_in) * RS_W'(pbc_ff);
      end
   end

   // Stage B: row byte offset.
   logic              sb_valid_ff, sb_on_ff;
   logic [DIM_W-1:0]  sb_col_ff, sb_row_ff;
   logic [RS_W-1:0]   sb_col_bytes_ff;
   logic [PROD_W-1:0] sb_row_bytes_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sb_valid_ff <= 1'b0;
      end else if (advance) begin
         sb_valid_ff <= sa_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sb_on_ff        <= sa_on_ff;
         sb_col_ff       <= sa_col_ff;
         sb_row_ff       <= sa_row_ff;
         sb_col_bytes_ff <= sa_col_bytes_ff;
         sb_row_bytes_ff <= PROD_W'(row_size_ff) * PROD_W'(sa_stored_ff);
      end
   end

   // Stage C: final address; a background beat reports all zero fields.
   logic                 sc_valid_ff;
   vspm_pkg::result_type sc_result_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sc_valid_ff <= 1'b0;
      end else if (advance) begin
         sc_valid_ff <= sb_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(offset_ff) + SUM_W'(sb_row_bytes_ff) + SUM_W'(sb_col_bytes_ff);
      if (advance) begin
         sc_result_ff.on_image <= sb_on_ff;
         if (sb_on_ff) begin
            sc_result_ff.source_col          <= vspm_pkg::SRC_W'(sb_col_ff);
            sc_result_ff.source_row          <= vspm_pkg::SRC_W'(sb_row_ff);
            sc_result_ff.source_byte_address <= vspm_pkg::ADDR_W'(sum);
         end else begin
            sc_result_ff.source_col          <= '0;
            sc_result_ff.source_row          <= '0;
            sc_result_ff.source_byte_address <= '0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Output register and skid entry. The skid entry fills only when the
   // output register holds a stalled beat and the pipeline delivers another.
   // ---------------------------------------------------------------------
   logic                 out_valid_ff;
   vspm_pkg::result_type out_ff, skid_ff;
   logic                 out_hold;

   assign out_hold = out_valid_ff && rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_hold) begin
         if (advance && sc_valid_ff) begin
            skid_valid_ff <= 1'b1;
         end
      end else if (skid_valid_ff) begin
         out_valid_ff  <= 1'b1;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= sc_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_hold) begin
         if (advance) begin
            skid_ff <= sc_result_ff;
         end
      end else if (skid_valid_ff) begin
         out_ff <= skid_ff;
      end else begin
         out_ff <= sc_result_ff;
      end
   end

   assign rsp_valid               = out_valid_ff;
   assign rsp_on_image            = out_ff.on_image;
   assign rsp_source_col          = out_ff.source_col;
   assign rsp_source_row          = out_ff.source_row;
   assign rsp_source_byte_address = out_ff.source_byte_address;

   // ---------------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------------

   // The skid entry is only ever filled behind a held output beat.
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry full while output register empty");

   // Both dividers run in lockstep on the same beats. The tags are only
   // meaningful alongside a valid beat.
   assert property (@(posedge clock) disable iff (reset)
      (col_valid == row_valid) && (!col_valid || (col_on == row_on)))
      else $error("column and row dividers out of step");

   // A background beat carries zero source fields.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_on_image) |->
         (rsp_source_col == '0) && (rsp_source_row == '0)
         && (rsp_source_byte_address == '0))
      else $error("background beat with nonzero source fields");

   // An image beat points inside the clamped source image.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_on_image) |->
         (32'(rsp_source_col) < 32'(wc_ff)) && (32'(rsp_source_row) < 32'(hc_ff)))
      else $error("source coordinate beyond image size");

endmodule

// File: verif/tb.sv
// Testbench for the viewport scale and pan mapper core.
`timescale 1ns / 1ps

// The testbench drives viewport pixel beats into the mapper and keeps its own
// model of the geometry: drawn size, pan clamping, centering, nearest source
// pixel and byte address. The expected result of each accepted beat goes into
// a queue, and each response beat is compared with the oldest entry. Registers
// are written only while the pipeline is empty. Each test task sets up the
// registers it needs and sends beats; the random tests use several idling patterns.
module tb;

   localparam int VW = 320;
   localparam int VH = 240;
   localparam int MAXDIM = 4096;
   localparam int PIPE_DEPTH = 26;
   localparam longint CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [vspm_pkg::VIEW_X_W-1:0] req_view_x = '0;
   logic [vspm_pkg::VIEW_Y_W-1:0] req_view_y = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_on_image;
   logic [vspm_pkg::SRC_W-1:0] rsp_source_col;
   logic [vspm_pkg::SRC_W-1:0] rsp_source_row;
   logic [vspm_pkg::ADDR_W-1:0] rsp_source_byte_address;
   logic csr_write_enable = 1'b0;
   logic [vspm_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [vspm_pkg::CSR_DATA_W-1:0] csr_write_data = '0;

   // Shadow copies of the configuration registers, raw as written.
   logic [12:0] img_w_reg, img_h_reg;
   logic [2:0] pix_bytes_reg;
   logic top_down_reg;
   logic [15:0] data_off_reg;
   logic [10:0] zoom_reg;
   logic [14:0] pan_x_reg, pan_y_reg;

   vspm_pkg::result_type mapped_q[$];
   int error_count = 0;
   longint cycle_count = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;

   viewport_scale_pan_mapper_core DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_view_x(req_view_x), .req_view_y(req_view_y),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_on_image(rsp_on_image), .rsp_source_col(rsp_source_col),
      .rsp_source_row(rsp_source_row),
      .rsp_source_byte_address(rsp_source_byte_address),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // The run ends here if the block stops making progress.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic longint clamp_int(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // Origin of the image on one axis once the pan is held inside the limit
   // that keeps the view covered.
   function automatic longint axis_start(longint drawn, longint view, logic [14:0] pan_raw);
      longint lim;
      longint pan;
      lim = 0;
      pan = longint'($signed(pan_raw));
      if (drawn > view) lim = (drawn - view) / 2;
      pan = clamp_int(pan, -lim, lim);
      return (view - drawn) / 2 + pan;
   endfunction

   function automatic vspm_pkg::result_type map_pixel(int vx, int vy);
      vspm_pkg::result_type r;
      longint w, h, pb, zoom, dw, dh, ox, oy, sx, sy, stored, pitch, addr;
      r = '0;
      w = clamp_int(img_w_reg, 1, MAXDIM);
      h = clamp_int(img_h_reg, 1, MAXDIM);
      pb = clamp_int(pix_bytes_reg, vspm_pkg::PIXEL_BYTES_MIN, vspm_pkg::PIXEL_BYTES_MAX);
      zoom = clamp_int(zoom_reg, 1, vspm_pkg::ZOOM_MAX);
      // Drawn size rounds up and never collapses below one pixel.
      dw = (w * zoom + vspm_pkg::ZOOM_ONE - 1) / vspm_pkg::ZOOM_ONE;
      dh = (h * zoom + vspm_pkg::ZOOM_ONE - 1) / vspm_pkg::ZOOM_ONE;
      if (dw < 1) dw = 1;
      if (dh < 1) dh = 1;
      ox = axis_start(dw, VW, pan_x_reg);
      oy = axis_start(dh, VH, pan_y_reg);
      if (vx >= VW || vy >= VH) return r;
      if (vx < ox || vx >= ox + dw || vy < oy || vy >= oy + dh) return r;
      sx = clamp_int(((vx - ox) * w) / dw, 0, w - 1);
      sy = clamp_int(((vy - oy) * h) / dh, 0, h - 1);
      stored = top_down_reg ? sy : (h - 1 - sy);
      // Stored rows are padded to a whole number of 32-bit words.
      pitch = ((pb * 8 * w + 31) / 32) * 4;
      addr = longint'(data_off_reg) + pitch * stored + sx * pb;
      r.on_image = 1'b1;
      r.source_col = sx[vspm_pkg::SRC_W-1:0];
      r.source_row = sy[vspm_pkg::SRC_W-1:0];
      r.source_byte_address = addr[vspm_pkg::ADDR_W-1:0];
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("ERROR at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
      error_count++;
   endtask

   // Response side: random stall, and every accepted beat is checked.
   always @(posedge clock) begin
      vspm_pkg::result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (mapped_q.size() == 0) begin
            report_mismatch("unexpected response beat", 1, 0);
         end else begin
            want = mapped_q.pop_front();
            if (rsp_on_image !== want.on_image)
               report_mismatch("on_image", rsp_on_image, want.on_image);
            if (rsp_source_col !== want.source_col)
               report_mismatch("source_col", rsp_source_col, want.source_col);
            if (rsp_source_row !== want.source_row)
               report_mismatch("source_row", rsp_source_row, want.source_row);
            if (rsp_source_byte_address !== want.source_byte_address)
               report_mismatch("source_byte_address", rsp_source_byte_address,
                               want.source_byte_address);
         end
      end
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   task automatic write_reg(logic [vspm_pkg::CSR_INDEX_W-1:0] idx,
                            logic [vspm_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         vspm_pkg::REG_IMAGE_WIDTH:       img_w_reg = data[12:0];
         vspm_pkg::REG_IMAGE_HEIGHT:      img_h_reg = data[12:0];
         vspm_pkg::REG_PIXEL_BYTES:       pix_bytes_reg = data[2:0];
         vspm_pkg::REG_ROWS_TOP_DOWN:     top_down_reg = data[0];
         vspm_pkg::REG_PIXEL_DATA_OFFSET: data_off_reg = data;
         vspm_pkg::REG_ZOOM_SCALE:        zoom_reg = data[10:0];
         vspm_pkg::REG_PAN_OFFSET_X:      pan_x_reg = data[14:0];
         vspm_pkg::REG_PAN_OFFSET_Y:      pan_y_reg = data[14:0];
         default: ;
      endcase
   endtask

   // Sends one beat; the valid stays high across back-to-back beats and is
   // lowered only when the sender idles.
   task automatic send_pixel(int vx, int vy);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_view_x <= vx[vspm_pkg::VIEW_X_W-1:0];
      req_view_y <= vy[vspm_pkg::VIEW_Y_W-1:0];
      @(posedge clock);
      while (req_stall) @(posedge clock);
      mapped_q.push_back(map_pixel(vx, vy));
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (mapped_q.size() != 0) @(negedge clock);
      repeat (PIPE_DEPTH + 4) @(negedge clock);
   endtask

   task automatic set_idling(int phase);
      case (phase % 4)
         0: begin send_idle_pct = 0;  stall_pct = 0;  end
         1: begin send_idle_pct = 70; stall_pct = 0;  end
         2: begin send_idle_pct = 0;  stall_pct = 70; end
         default: begin send_idle_pct = 23; stall_pct = 23; end
      endcase
   endtask

   // Random pixels, mostly inside the view and biased toward the view edges.
   // The idling pattern changes every ten beats so that each call walks
   // through all of them.
   task automatic random_pixels(int count);
      int vx, vy;
      for (int i = 0; i < count; i++) begin
         if (i % 10 == 0) set_idling(i / 10);
         case ($urandom_range(9))
            0: begin vx = $urandom_range(511); vy = $urandom_range(255); end
            1: begin vx = $urandom_range(1) ? 0 : VW - 1; vy = $urandom_range(VH - 1); end
            default: begin vx = $urandom_range(VW - 1); vy = $urandom_range(VH - 1); end
         endcase
         send_pixel(vx, vy);
      end
      drain();
   endtask

   task automatic test_reset_values();
      send_pixel(0, 0);
      send_pixel(VW / 2, VH / 2);
      send_pixel(VW / 2 - 1, VH / 2 - 1);
      send_pixel(511, 255);
      drain();
   endtask

   // Extremes of the fields and the register saturation cases.
   task automatic test_directed();
      write_reg(vspm_pkg::REG_IMAGE_WIDTH, 16'd8191);
      write_reg(vspm_pkg::REG_IMAGE_HEIGHT, 16'd0);
      write_reg(vspm_pkg::REG_PIXEL_BYTES, 16'd7);
      write_reg(vspm_pkg::REG_ROWS_TOP_DOWN, 16'd1);
      write_reg(vspm_pkg::REG_PIXEL_DATA_OFFSET, 16'hFFFF);
      write_reg(vspm_pkg::REG_ZOOM_SCALE, 16'd2047);
      write_reg(vspm_pkg::REG_PAN_OFFSET_X, 16'h7FFF);
      write_reg(vspm_pkg::REG_PAN_OFFSET_Y, 16'h3FFF);
      send_pixel(0, 0);
      send_pixel(VW - 1, VH - 1);
      send_pixel(VW, 0);
      send_pixel(0, VH);
      send_pixel(511, 255);
      send_pixel(170, 85);
      drain();
      write_reg(vspm_pkg::REG_IMAGE_WIDTH, 16'd0);
      write_reg(vspm_pkg::REG_IMAGE_HEIGHT, 16'd4096);
      write_reg(vspm_pkg::REG_PIXEL_BYTES, 16'd0);
      write_reg(vspm_pkg::REG_ROWS_TOP_DOWN, 16'd0);
      write_reg(vspm_pkg::REG_PIXEL_DATA_OFFSET, 16'd0);
      write_reg(vspm_pkg::REG_ZOOM_SCALE, 16'd0);
      write_reg(vspm_pkg::REG_PAN_OFFSET_X, 16'h4000);
      write_reg(vspm_pkg::REG_PAN_OFFSET_Y, 16'h2000);
      send_pixel(VW / 2, VH / 2);
      send_pixel(VW / 2 - 1, VH / 2 - 1);
      send_pixel(0, 0);
      drain();
      // Large image zoomed far in: the address reaches its top bits.
      write_reg(vspm_pkg::REG_IMAGE_WIDTH, 16'd4096);
      write_reg(vspm_pkg::REG_PIXEL_BYTES, 16'd4);
      write_reg(vspm_pkg::REG_ZOOM_SCALE, 16'd1024);
      write_reg(vspm_pkg::REG_PAN_OFFSET_X, 16'd0);
      write_reg(vspm_pkg::REG_PAN_OFFSET_Y, 16'd0);
      write_reg(vspm_pkg::REG_PIXEL_DATA_OFFSET, 16'hFFFF);
      send_pixel(0, 0);
      send_pixel(VW - 1, VH - 1);
      send_pixel(VW - 1, 0);
      drain();
   endtask

   task automatic random_config(bit small_image);
      int w, h;
      w = small_image ? $urandom_range(1, 64) : $urandom_range(0, 8191);
      h = small_image ? $urandom_range(1, 64) : $urandom_range(0, 8191);
      write_reg(vspm_pkg::REG_IMAGE_WIDTH, 16'(w));
      write_reg(vspm_pkg::REG_IMAGE_HEIGHT, 16'(h));
      write_reg(vspm_pkg::REG_PIXEL_BYTES, 16'($urandom_range(7)));
      write_reg(vspm_pkg::REG_ROWS_TOP_DOWN, 16'($urandom_range(1)));
      write_reg(vspm_pkg::REG_PIXEL_DATA_OFFSET, 16'($urandom_range(65535)));
      write_reg(vspm_pkg::REG_ZOOM_SCALE, 16'($urandom_range(2047)));
      write_reg(vspm_pkg::REG_PAN_OFFSET_X, 16'($urandom_range(32767)));
      write_reg(vspm_pkg::REG_PAN_OFFSET_Y, 16'($urandom_range(32767)));
   endtask

   task automatic test_random_settings();
      for (int k = 0; k < 14; k++) begin
         random_config(k % 2 == 0);
         random_pixels(50);
      end
   endtask

   initial begin
      img_w_reg = vspm_pkg::IMAGE_DIM_RESET;
      img_h_reg = vspm_pkg::IMAGE_DIM_RESET;
      pix_bytes_reg = vspm_pkg::PIXEL_BYTES_RESET;
      top_down_reg = 1'b0;
      data_off_reg = vspm_pkg::OFFSET_RESET;
      zoom_reg = vspm_pkg::ZOOM_RESET;
      pan_x_reg = '0;
      pan_y_reg = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_reset_values();
      test_directed();
      test_random_settings();
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
